FILE: design/tlb_pkg.sv
// Shared types and constants for the two-level bitmap find-first-set block.
package tlb_pkg;

  // Command codes carried on the input channel.
  localparam logic [2:0] CMD_TEST  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_UNSET = 3'd2;
  localparam logic [2:0] CMD_FIND  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_FILL  = 3'd5;

  localparam int REGION_COUNT = 16;
  localparam int WORD_BITS    = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic rd_pos;     // read the word addressed by the position
    logic rd_scan;    // read the word at the scan pointer
    logic scan_init;  // point the scan at the first word of the lowest region
    logic scan_step;  // advance the scan pointer
    logic apply;      // apply test/set/unset with the read word
    logic find_hit;   // record a find result from the read word
    logic sweep_init; // start a clear or fill sweep
    logic sweep_step; // write one word of the sweep
    logic finish_sw;  // update counts and summary after a sweep
    logic out_load;   // move the result into the output register
  } tlb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] command;
    logic       summary_zero;
    logic       word_nonzero;
    logic       scan_last;
    logic       sweep_last;
  } tlb_stat_t;

endpackage

FILE: design/tlb_if.sv
// Valid/ready channel interface carrying one payload.
interface tlb_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/tlb_ram.sv
// Generic single-port RAM with registered read.
module tlb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/tlb_ctrl.sv
// Controller state machine sequencing each command through the datapath.
module tlb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tlb_pkg::tlb_stat_t stat,
  output tlb_pkg::tlb_cmd_t  cmd
);
  import tlb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_DEC   = 9'b0_0000_0010,
    S_RDWT  = 9'b0_0000_0100,
    S_APPLY = 9'b0_0000_1000,
    S_SCAN  = 9'b0_0001_0000,
    S_SWEEP = 9'b0_0010_0000,
    S_DONE  = 9'b0_0100_0000,
    S_SRD   = 9'b0_1000_0000,
    S_INIT  = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_full;

  assign in_ready  = (state == S_IDLE) && (!out_full || out_ready);
  assign out_valid = out_full;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        // Zero the whole store once after reset, one word per cycle.
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.command)
          CMD_TEST, CMD_SET, CMD_UNSET: begin
            cmd.rd_pos = 1'b1;
            state_next = S_RDWT;
          end
          CMD_FIND: begin
            if (stat.summary_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next = S_SRD;
            end
          end
          CMD_CLEAR, CMD_FILL: begin
            cmd.sweep_init = 1'b1;
            state_next = S_SWEEP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RDWT: begin
        // Keep the position address so the read word stays in place.
        cmd.rd_pos = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_DONE;
      end
      S_SRD: begin
        cmd.rd_scan = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.word_nonzero) begin
          cmd.find_hit = 1'b1;
          state_next = S_DONE;
        end else if (stat.scan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_SRD;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.finish_sw = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end
endmodule

FILE: design/tlb_dp.sv
// Datapath: bit store, counters, summary mask, scan and sweep pointers.
module tlb_dp #(
  parameter int TOTAL_BITS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         in_command,
  input  logic [15:0]        in_position,
  input  tlb_pkg::tlb_cmd_t  cmd,
  output tlb_pkg::tlb_stat_t stat,
  output logic               res_ok,
  output logic [15:0]        res_found,
  output logic [16:0]        res_total,
  output logic [15:0]        res_mask
);
  import tlb_pkg::*;

  localparam int WORDS      = TOTAL_BITS / WORD_BITS;
  localparam int AW         = $clog2(WORDS);
  localparam int RWORDS     = WORDS / REGION_COUNT;
  localparam int RW_BITS    = $clog2(RWORDS);
  localparam int REGION_B   = TOTAL_BITS / REGION_COUNT;
  localparam int CW         = $clog2(REGION_B + 1);
  localparam int TW         = $clog2(TOTAL_BITS + 1);

  logic [2:0]             command;
  logic [15:0]            position;
  logic                   in_map;
  logic [AW-1:0]          ptr;
  logic                   sweep_fill;
  logic [15:0]            summary;
  logic [CW-1:0]          region_ones [REGION_COUNT];
  logic [TW-1:0]          ones_count;
  logic                   ok_r;
  logic [15:0]            found_r;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [WORD_BITS-1:0]   rdata;
  logic [3:0]             low_region;
  logic [5:0]             low_bit;
  logic [3:0]             pos_region;
  logic [5:0]             pos_bit;
  logic                   cur;
  logic [WORD_BITS-1:0]   bitm;

  assign in_map     = ({5'd0, position} < 21'(TOTAL_BITS));
  assign pos_region = 4'(position >> $clog2(REGION_B));
  assign pos_bit    = position[5:0];
  assign bitm       = WORD_BITS'(1) << pos_bit;
  assign cur        = in_map && ((rdata & bitm) != '0);

  // Lowest non-empty region and lowest set bit of the read word.
  always_comb begin
    low_region = '0;
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      if (summary[i]) low_region = 4'(i);
    end
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rdata[i]) low_bit = 6'(i);
    end
  end

  // Memory port: sweep writes, set/unset write-back, position or scan reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rdata;
    ram_addr  = ptr;
    if (cmd.sweep_step) begin
      ram_we    = 1'b1;
      ram_wdata = {WORD_BITS{sweep_fill}};
    end else if (cmd.rd_pos || cmd.apply) begin
      ram_addr = AW'(position >> 6);
      if (cmd.apply && in_map) begin
        if (command == CMD_SET && !cur) begin
          ram_we = 1'b1; ram_wdata = rdata | bitm;
        end else if (command == CMD_UNSET && cur) begin
          ram_we = 1'b1; ram_wdata = rdata & ~bitm;
        end
      end
    end else if (cmd.rd_scan) begin
      ram_addr = ptr;
    end
  end

  tlb_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
  );

  assign stat.command      = command;
  assign stat.summary_zero = (summary == '0);
  assign stat.word_nonzero = (rdata != '0);
  assign stat.scan_last    = (ptr == AW'(WORDS - 1));
  assign stat.sweep_last   = (ptr == AW'(WORDS - 1));

  // Pointer and sweep value; reset starts the clearing pass at word zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      sweep_fill <= 1'b0;
    end else begin
      if (cmd.scan_init) ptr <= AW'(low_region) << RW_BITS;
      if (cmd.scan_step) ptr <= ptr + 1'b1;
      if (cmd.sweep_init) begin
        ptr        <= '0;
        sweep_fill <= (command == CMD_FILL);
      end
      if (cmd.sweep_step) ptr <= ptr + 1'b1;
    end
  end

  // Captured item and per-item result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command  <= in_command;
      position <= in_position;
      ok_r     <= 1'b0;
      found_r  <= '0;
    end
    if (cmd.find_hit) begin
      ok_r    <= 1'b1;
      found_r <= 16'({ptr, low_bit});
    end
    if (cmd.finish_sw) ok_r <= 1'b1;
    if (cmd.apply) begin
      if (command == CMD_TEST) ok_r <= cur;
      else ok_r <= in_map && ((command == CMD_SET) ? !cur : cur);
    end
    if (cmd.out_load) begin
      res_ok    <= ok_r;
      res_found <= found_r;
      res_total <= 17'(ones_count);
      res_mask  <= summary;
    end
  end

  // Counts and summary; they reset to zero while the store is being cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      summary    <= '0;
      ones_count <= '0;
      for (int r = 0; r < REGION_COUNT; r++) region_ones[r] <= '0;
    end else if (cmd.finish_sw) begin
      summary    <= sweep_fill ? 16'hFFFF : 16'h0000;
      ones_count <= sweep_fill ? TW'(TOTAL_BITS) : '0;
      for (int r = 0; r < REGION_COUNT; r++) begin
        region_ones[r] <= sweep_fill ? CW'(REGION_B) : '0;
      end
    end else if (cmd.apply && in_map) begin
      if (command == CMD_SET && !cur) begin
        region_ones[pos_region] <= region_ones[pos_region] + 1'b1;
        ones_count <= ones_count + 1'b1;
        summary[pos_region] <= 1'b1;
      end else if (command == CMD_UNSET && cur) begin
        region_ones[pos_region] <= region_ones[pos_region] - 1'b1;
        ones_count <= ones_count - 1'b1;
        if (region_ones[pos_region] == CW'(1)) summary[pos_region] <= 1'b0;
      end
    end
  end
endmodule

FILE: design/two_level_bitmap_find_first_set.sv
// Top level of the two-level bitmap find-first-set block.
// One command in, one result out, all through a single RAM port. Test, set
// and unset read the addressed word and write it back when the bit changes.
// Find scans the words of the lowest non-empty region, at most
// TOTAL_BITS/16/64 words; with an empty summary it skips the scan. Clear and
// fill write one 64-bit word per cycle. Unknown commands go straight to the
// result. A result stall holds the block until the output register is free.
// After reset the block clears the store by itself, during which no command
// is taken.
module two_level_bitmap_find_first_set #(
  parameter int TOTAL_BITS = 65536
) (
  input logic clk,
  input logic rst,
  tlb_if.sink   in_ch,
  tlb_if.source out_ch
);
  import tlb_pkg::*;

  tlb_cmd_t  cmd;
  tlb_stat_t stat;

  tlb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tlb_dp #(.TOTAL_BITS(TOTAL_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .in_command(in_ch.data.command), .in_position(in_ch.data.bit_position),
    .cmd(cmd), .stat(stat),
    .res_ok(out_ch.data.ok), .res_found(out_ch.data.found_position),
    .res_total(out_ch.data.ones_total), .res_mask(out_ch.data.region_mask)
  );
endmodule

FILE: design/tlb_checker.sv
// Port-level checker for the bitmap block, bound to the top level.
module tlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [15:0] out_found,
  input logic [16:0] out_total,
  input logic [15:0] out_mask
);
  // A waiting result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result changed while stalled");

  // An empty map reports an empty summary.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_total == 17'd0 |-> out_mask == 16'd0)
    else $error("summary set with zero count");

  // A set bit count implies a non-empty summary.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_total != 17'd0 |-> out_mask != 16'd0)
    else $error("summary empty with set bits");

  // A nonzero found position only comes with a successful find.
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_found != 16'd0 |-> out_ok)
    else $error("found position without success");

  // A transfer in is not taken in the cycle right after another.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken too early");
endmodule

bind two_level_bitmap_find_first_set tlb_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_ok(out_ch.data.ok), .out_found(out_ch.data.found_position),
  .out_total(out_ch.data.ones_total), .out_mask(out_ch.data.region_mask)
);
